>>> rtl/core/mprm_pkg.sv
// Shared types and constants for the multi-pattern reply matcher.
// Used by the controller, the datapath and the top level; depends on nothing.
package mprm_pkg;

    // Default sizes of the pattern table.
    localparam int MAX_PATTERNS_DEF    = 64;
    localparam int MAX_PATTERN_LEN_DEF = 32;

    // Fixed field widths of the channels.
    localparam int ACTION_W   = 3;
    localparam int PINDEX_W   = 6;
    localparam int CHARPOS_W  = 5;
    localparam int BYTE_W     = 8;
    localparam int PCOUNT_W   = 7;
    localparam int STATUS_W   = 3;
    localparam int TIMEOUT_W  = 16;

    // Timeout register value after reset, and the saturation limit of the idle count.
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd200;
    localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = 16'hFFFF;

    // Action codes of an input word.
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD  = 3'd0,
        ACT_START = 3'd1,
        ACT_RECV  = 3'd2,
        ACT_TICK  = 3'd3,
        ACT_RXERR = 3'd4
    } action_t;

    // Status codes of a result word.
    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_WAITING = 3'd1,
        ST_MATCHED = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_RXERR   = 3'd4
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_WALK,
        CTL_POST
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;     // Accept the input word and apply its immediate effects.
        logic publish;  // Move the pending result into the output register.
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_walk;  // The offered word needs a walk over the patterns.
        logic walk_done;   // The walk has finished and the result is pending.
        logic out_free;    // The output register can take a word this cycle.
    } dp_stat_t;

endpackage

>>> rtl/core/mprm_ctl.sv
// Controller state machine of the multi-pattern reply matcher.
// Depends on mprm_pkg for the state type and the command and status structs.
module mprm_ctl
    import mprm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd.take    = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            CTL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = stat.needs_walk ? CTL_WALK : CTL_POST;
                end
            end
            CTL_WALK: begin
                if (stat.walk_done) begin
                    state_next = CTL_POST;
                end
            end
            CTL_POST: begin
                if (stat.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = CTL_IDLE;
                end
            end
            default: begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/mprm_dp.sv
// Datapath of the multi-pattern reply matcher: pattern table, position memory,
// the pattern walk pipeline, timers and the result registers. Depends on mprm_pkg.
module mprm_dp
    import mprm_pkg::*;
#(
    parameter int MAX_PATTERNS    = MAX_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctl_cmd_t             cmd,
    output dp_stat_t             stat,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic [PINDEX_W-1:0]  s_pattern_index,
    input  logic [CHARPOS_W-1:0] s_char_position,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic [PCOUNT_W-1:0]  s_pattern_count,
    input  logic                 cfg_valid,
    input  logic [TIMEOUT_W-1:0] cfg_timeout_ticks,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [PINDEX_W-1:0]  m_match_index
);

    localparam int PIDX_W      = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CNT_W       = $clog2(MAX_PATTERNS + 1);
    localparam int CPOS_W      = $clog2(MAX_PATTERN_LEN);
    localparam int POS_W       = $clog2(MAX_PATTERN_LEN + 1);
    localparam int ADDR_W      = PIDX_W + CPOS_W;
    localparam int STORE_DEPTH = MAX_PATTERNS << CPOS_W;

    // Pattern table, one row per pattern, and the match position of each pattern.
    logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
    logic [POS_W-1:0]  pos_mem   [MAX_PATTERNS];

    // A position entry that is not valid reads as zero; the empty flag mirrors
    // whether a pattern's first byte is zero.
    logic [MAX_PATTERNS-1:0] pos_valid_reg;
    logic [MAX_PATTERNS-1:0] empty_reg;

    logic [CNT_W-1:0]     active_reg;
    logic [CNT_W-1:0]     p0_reg;
    logic                 walking_reg;
    logic                 walk_start_reg;
    logic                 found_reg;
    logic                 v1_reg;
    logic                 v2_reg;
    logic                 waiting_reg;
    logic [PIDX_W-1:0]    p1_reg;
    logic [PIDX_W-1:0]    p2_reg;
    logic [PIDX_W-1:0]    win_reg;
    logic [POS_W-1:0]     pos_rd_reg;
    logic [POS_W-1:0]     pos2_reg;
    logic [BYTE_W-1:0]    cur_rd_reg;
    logic [BYTE_W-1:0]    nxt_rd_reg;
    logic [BYTE_W-1:0]    rx_byte_reg;
    logic [TIMEOUT_W-1:0] idle_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    status_t              res_status_reg;
    logic [PIDX_W-1:0]    res_index_reg;
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [PINDEX_W-1:0]  m_index_reg;

    logic                 load_ok;
    logic [ADDR_W-1:0]    load_addr;
    logic                 issue;
    logic                 walk_done;
    logic [POS_W-1:0]     pos_val;
    logic [POS_W-1:0]     pos_inc1;
    logic                 hit;
    logic [POS_W-1:0]     pos2_inc;
    logic [POS_W-1:0]     new_pos;
    logic                 fin;
    logic [TIMEOUT_W-1:0] idle_inc;
    logic [CNT_W-1:0]     count_sat;
    status_t              hold_status;

    // Decode of the offered word.
    assign load_ok   = cmd.take && (s_action == ACT_LOAD)
                     && (32'(s_pattern_index) < MAX_PATTERNS)
                     && (32'(s_char_position) < MAX_PATTERN_LEN);
    assign load_addr = {PIDX_W'(s_pattern_index), CPOS_W'(s_char_position)};
    assign count_sat = (32'(s_pattern_count) > MAX_PATTERNS) ? CNT_W'(MAX_PATTERNS)
                                                           : CNT_W'(s_pattern_count);
    assign hold_status = waiting_reg ? ST_WAITING : ST_IDLE;
    assign idle_inc    = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

    // Walk control: one pattern is issued per cycle, the pipeline drains after the last.
    assign issue     = walking_reg && (p0_reg != active_reg);
    assign walk_done = walking_reg && !issue && !v1_reg && !v2_reg;

    // Stage one: the stored position, or zero if the entry was cleared by a start.
    assign pos_val  = pos_valid_reg[p1_reg] ? pos_rd_reg : '0;
    assign pos_inc1 = pos_val + POS_W'(1);

    // Stage two: compare the received byte and decide whether the pattern has ended.
    assign hit      = (pos2_reg != POS_W'(MAX_PATTERN_LEN)) && (cur_rd_reg == rx_byte_reg);
    assign pos2_inc = pos2_reg + POS_W'(1);
    assign new_pos  = hit ? pos2_inc : '0;
    always_comb begin
        if (walk_start_reg || !hit) begin
            fin = empty_reg[p2_reg];
        end else begin
            fin = (pos2_inc == POS_W'(MAX_PATTERN_LEN)) || (nxt_rd_reg == '0);
        end
    end

    assign stat.needs_walk = (s_action == ACT_START) || ((s_action == ACT_RECV) && waiting_reg);
    assign stat.walk_done  = walk_done;
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_match_index = m_index_reg;

    // Control state: matcher state, walk counters, timers and result handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_valid_reg  <= '0;
            active_reg     <= '0;
            p0_reg         <= '0;
            walking_reg    <= 1'b0;
            walk_start_reg <= 1'b0;
            found_reg      <= 1'b0;
            win_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            waiting_reg    <= 1'b0;
            idle_reg       <= '0;
            timeout_reg    <= TIMEOUT_RESET;
            res_status_reg <= ST_IDLE;
            res_index_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_timeout_ticks;
            end

            // Immediate effects of an accepted word.
            if (cmd.take) begin
                res_status_reg <= hold_status;
                res_index_reg  <= '0;
                unique case (s_action)
                    ACT_LOAD: begin
                    end
                    ACT_START: begin
                        active_reg     <= count_sat;
                        pos_valid_reg  <= '0;
                        idle_reg       <= '0;
                        waiting_reg    <= 1'b1;
                        p0_reg         <= '0;
                        found_reg      <= 1'b0;
                        walking_reg    <= 1'b1;
                        walk_start_reg <= 1'b1;
                    end
                    ACT_RECV: begin
                        if (waiting_reg) begin
                            idle_reg       <= '0;
                            p0_reg         <= '0;
                            found_reg      <= 1'b0;
                            walking_reg    <= 1'b1;
                            walk_start_reg <= 1'b0;
                        end
                    end
                    ACT_TICK: begin
                        if (waiting_reg) begin
                            idle_reg <= idle_inc;
                            if (idle_inc >= timeout_reg) begin
                                waiting_reg    <= 1'b0;
                                res_status_reg <= ST_TIMEOUT;
                            end
                        end
                    end
                    ACT_RXERR: begin
                        if (waiting_reg) begin
                            waiting_reg    <= 1'b0;
                            res_status_reg <= ST_RXERR;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Walk pipeline valids and the issue counter.
            if (issue) begin
                p0_reg <= p0_reg + CNT_W'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;

            // The updated position is valid from now on.
            if (v2_reg && !walk_start_reg) begin
                pos_valid_reg[p2_reg] <= 1'b1;
            end

            // The first finished pattern in walk order is the lowest-numbered one.
            if (v2_reg && fin && !found_reg) begin
                found_reg <= 1'b1;
                win_reg   <= p2_reg;
            end

            if (walk_done) begin
                walking_reg <= 1'b0;
                if (found_reg) begin
                    waiting_reg    <= 1'b0;
                    res_status_reg <= ST_MATCHED;
                    res_index_reg  <= win_reg;
                end else begin
                    res_status_reg <= ST_WAITING;
                end
            end

            // Output word handshake.
            if (cmd.publish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Pattern table: loads write one byte, the walk reads the current and next byte.
    always_ff @(posedge aclk) begin
        if (load_ok) begin
            store_mem[load_addr] <= s_data_byte;
        end
        cur_rd_reg <= store_mem[{p1_reg, pos_val[CPOS_W-1:0]}];
        nxt_rd_reg <= store_mem[{p1_reg, pos_inc1[CPOS_W-1:0]}];
    end

    // Position memory: read at issue, written back from the last stage.
    always_ff @(posedge aclk) begin
        pos_rd_reg <= pos_mem[p0_reg[PIDX_W-1:0]];
        if (v2_reg && !walk_start_reg) begin
            pos_mem[p2_reg] <= new_pos;
        end
    end

    // Payload registers of the walk pipeline, the empty flags and the output word.
    always_ff @(posedge aclk) begin
        p1_reg   <= p0_reg[PIDX_W-1:0];
        p2_reg   <= p1_reg;
        pos2_reg <= pos_val;
        if (cmd.take) begin
            rx_byte_reg <= s_data_byte;
        end
        if (load_ok && (s_char_position == '0)) begin
            empty_reg[PIDX_W'(s_pattern_index)] <= (s_data_byte == '0);
        end
        if (cmd.publish) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= PINDEX_W'(res_index_reg);
        end
    end

`ifndef SYNTHESIS
    // A walk that found a finished pattern ends the wait with a match.
    a_match_ends_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_done && found_reg |=> !waiting_reg && (res_status_reg == ST_MATCHED))
        else $error("match did not end the wait");

    // Only active patterns enter the pipeline.
    a_issue_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (CNT_W'(p1_reg) < active_reg))
        else $error("walk issued a pattern beyond the active count");

    // No word is taken while a walk is running.
    a_no_take_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        walking_reg |-> !cmd.take)
        else $error("word taken during a walk");

    // A match position never runs past the pattern length.
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (pos2_reg <= POS_W'(MAX_PATTERN_LEN)))
        else $error("match position beyond pattern length");
`endif

endmodule

>>> rtl/core/multi_pattern_reply_matcher.sv
// A load, tick, error or unknown word goes from the idle state to the post state, and its result word
// is registered in the output register once that register is free. A start or a received byte while
// waiting first walks the active patterns, one per cycle through the position memory.
// The matcher takes one word at a time: it takes no new word until the last result word is published.
// Reset: the matcher is idle, all positions zero, timeout 200; the pattern table is undefined
// until loaded.
module multi_pattern_reply_matcher
    import mprm_pkg::*;
#(
    parameter int MAX_PATTERNS    = MAX_PATTERNS_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic [PINDEX_W-1:0]  s_pattern_index,
    input  logic [CHARPOS_W-1:0] s_char_position,
    input  logic [BYTE_W-1:0]    s_data_byte,
    input  logic [PCOUNT_W-1:0]  s_pattern_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIMEOUT_W-1:0] cfg_timeout_ticks,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [PINDEX_W-1:0]  m_match_index
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // The timeout register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    // Controller.
    mprm_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath.
    mprm_dp #(
        .MAX_PATTERNS    (MAX_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_action          (s_action),
        .s_pattern_index   (s_pattern_index),
        .s_char_position   (s_char_position),
        .s_data_byte       (s_data_byte),
        .s_pattern_count   (s_pattern_count),
        .cfg_valid         (cfg_valid),
        .cfg_timeout_ticks (cfg_timeout_ticks),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_match_index     (m_match_index)
    );

endmodule

>>> sim/multi_pattern_reply_matcher_tb.sv
// Self-checking testbench for the multi-pattern reply matcher: drives pattern loads, starts,
// received bytes, ticks and errors, and compares every result word with its own prediction.
// Depends on mprm_pkg and the multi_pattern_reply_matcher RTL only.
`timescale 1ns / 1ps

module multi_pattern_reply_matcher_tb;
    import mprm_pkg::*;

    localparam int NPAT         = MAX_PATTERNS_DEF;
    localparam int PLEN         = MAX_PATTERN_LEN_DEF;
    localparam int STALL_CYCLES = 300;
    localparam int UNKNOWN_LO   = ACT_RXERR + 1;
    localparam int UNKNOWN_HI   = (1 << ACTION_W) - 1;
    localparam logic [BYTE_W-1:0] CH_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_B = 8'h62;

    // One input word and one result word, at the widths of the ports.
    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [PINDEX_W-1:0]  pidx;
        logic [CHARPOS_W-1:0] cpos;
        logic [BYTE_W-1:0]    data;
        logic [PCOUNT_W-1:0]  count;
    } in_word_t;

    typedef struct packed {
        status_t              status;
        logic [PINDEX_W-1:0]  index;
    } reply_t;

    logic                 aclk              = 1'b0;
    logic                 aresetn           = 1'b0;
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic [ACTION_W-1:0]  s_action          = '0;
    logic [PINDEX_W-1:0]  s_pattern_index   = '0;
    logic [CHARPOS_W-1:0] s_char_position   = '0;
    logic [BYTE_W-1:0]    s_data_byte       = '0;
    logic [PCOUNT_W-1:0]  s_pattern_count   = '0;
    logic                 cfg_valid         = 1'b0;
    logic                 cfg_ready;
    logic [TIMEOUT_W-1:0] cfg_timeout_ticks = '0;
    logic                 m_valid;
    logic                 m_ready           = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [PINDEX_W-1:0]  m_match_index;

    // Predicted matcher state.
    logic [BYTE_W-1:0]    pattern_bytes [NPAT][PLEN];
    bit                   byte_loaded   [NPAT][PLEN] = '{default: '0};
    logic [5:0]           scan_pos      [NPAT]       = '{default: '0};
    int                   armed_count    = 0;
    logic [TIMEOUT_W-1:0] idle_count     = '0;
    bit                   awaiting_reply = 1'b0;
    logic [TIMEOUT_W-1:0] timeout_limit  = TIMEOUT_RESET;

    reply_t expected_replies [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_asks    = 0;
    int stall_seen    = 0;
    int stall_left    = 0;
    int words_sent    = 0;
    int replies_seen  = 0;
    int matches_seen  = 0;
    int timeouts_seen = 0;
    int rxerrs_seen   = 0;
    int error_count   = 0;

    multi_pattern_reply_matcher dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_pattern_index   (s_pattern_index),
        .s_char_position   (s_char_position),
        .s_data_byte       (s_data_byte),
        .s_pattern_count   (s_pattern_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_timeout_ticks (cfg_timeout_ticks),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_match_index     (m_match_index)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Run limit, well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Lowest-numbered armed pattern that has reached its end wins and ends the wait.
    function automatic reply_t pick_winner();
        reply_t r;
        r.status = ST_WAITING;
        r.index  = '0;
        for (int p = 0; p < armed_count; p++) begin
            if (scan_pos[p] >= PLEN || pattern_bytes[p][scan_pos[p]] == '0) begin
                awaiting_reply = 1'b0;
                r.status = ST_MATCHED;
                r.index  = PINDEX_W'(p);
                return r;
            end
        end
        return r;
    endfunction

    // Applies one accepted word to the predicted state and returns its result word.
    function automatic reply_t predict_reply(input in_word_t w);
        reply_t r;
        r.status = awaiting_reply ? ST_WAITING : ST_IDLE;
        r.index  = '0;
        case (w.action)
            ACT_LOAD: begin
                pattern_bytes[w.pidx][w.cpos] = w.data;
                byte_loaded[w.pidx][w.cpos]   = 1'b1;
            end
            ACT_START: begin
                armed_count = (w.count > NPAT) ? NPAT : int'(w.count);
                foreach (scan_pos[i]) scan_pos[i] = '0;
                idle_count     = '0;
                awaiting_reply = 1'b1;
                r = pick_winner();
            end
            ACT_RECV: if (awaiting_reply) begin
                idle_count = '0;
                // Naive scan: a mismatch drops back to zero without comparing again.
                for (int p = 0; p < armed_count; p++) begin
                    if (scan_pos[p] < PLEN && pattern_bytes[p][scan_pos[p]] == w.data)
                        scan_pos[p] = scan_pos[p] + 1'b1;
                    else
                        scan_pos[p] = '0;
                end
                r = pick_winner();
            end
            ACT_TICK: if (awaiting_reply) begin
                if (idle_count != IDLE_MAX) idle_count = idle_count + 1'b1;
                if (idle_count >= timeout_limit) begin
                    awaiting_reply = 1'b0;
                    r.status = ST_TIMEOUT;
                end
            end
            ACT_RXERR: if (awaiting_reply) begin
                awaiting_reply = 1'b0;
                r.status = ST_RXERR;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Compares each accepted result word with the oldest prediction.
    always @(posedge aclk) begin : check_replies
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected result word: status %0d, match_index %0d",
                       m_status, m_match_index);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                replies_seen++;
                if (want.status == ST_MATCHED) matches_seen++;
                if (want.status == ST_TIMEOUT) timeouts_seen++;
                if (want.status == ST_RXERR)   rxerrs_seen++;
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    error_count++;
                end
                if (m_match_index !== want.index) begin
                    $error("match_index: expected %0d, got %0d", want.index, m_match_index);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random hold-offs, plus a long stall counted here when one is asked for.
    always @(negedge aclk) begin
        if (stall_asks != stall_seen) begin
            stall_seen <= stall_asks;
            stall_left <= STALL_CYCLES;
            m_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Offers one word, with random gaps before it, and records its prediction on acceptance.
    task automatic send_word(input in_word_t w);
        @(negedge aclk);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= w.action;
        s_pattern_index <= w.pidx;
        s_char_position <= w.cpos;
        s_data_byte     <= w.data;
        s_pattern_count <= w.count;
        do @(posedge aclk); while (!s_ready);
        expected_replies.push_back(predict_reply(w));
        words_sent++;
    endtask

    // A word with every field random; callers set the fields that matter.
    function automatic in_word_t rand_word(input logic [ACTION_W-1:0] act);
        in_word_t w;
        w.action = act;
        w.pidx   = PINDEX_W'($urandom());
        w.cpos   = CHARPOS_W'($urandom());
        w.data   = BYTE_W'($urandom());
        w.count  = PCOUNT_W'($urandom());
        return w;
    endfunction

    task automatic send_load(input int p, input int c, input logic [BYTE_W-1:0] v);
        in_word_t w;
        w = rand_word(ACT_LOAD);
        w.pidx = PINDEX_W'(p);
        w.cpos = CHARPOS_W'(c);
        w.data = v;
        send_word(w);
    endtask

    task automatic send_start(input int n);
        in_word_t w;
        w = rand_word(ACT_START);
        w.count = PCOUNT_W'(n);
        send_word(w);
    endtask

    task automatic send_recv(input logic [BYTE_W-1:0] b);
        in_word_t w;
        w = rand_word(ACT_RECV);
        w.data = b;
        send_word(w);
    endtask

    task automatic send_plain(input logic [ACTION_W-1:0] act);
        send_word(rand_word(act));
    endtask

    // Drops valid and waits until every predicted result word has arrived.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_replies.size() != 0) @(negedge aclk);
    endtask

    // Writes the timeout register once every predicted result word has arrived.
    task automatic write_timeout(input logic [TIMEOUT_W-1:0] ticks);
        wait_drained();
        cfg_valid         <= 1'b1;
        cfg_timeout_ticks <= ticks;
        do @(posedge aclk); while (!cfg_ready);
        timeout_limit = ticks;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Bytes from a small alphabet, so that partial matches are common.
    function automatic logic [BYTE_W-1:0] alpha_byte();
        if ($urandom_range(99, 0) < 85) return CH_A + BYTE_W'($urandom_range(2, 0));
        return BYTE_W'($urandom_range(255, 1));
    endfunction

    function automatic int pick_count();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 5)  return 0;
        if (roll < 70) return $urandom_range(8, 1);
        if (roll < 88) return $urandom_range(64, 9);
        return $urandom_range(127, 65);
    endfunction

    // Keeps a pattern's bytes loaded up to its terminator: if the write would open a path
    // into bytes never loaded, a zero is written instead.
    function automatic logic [BYTE_W-1:0] keep_terminated(input int p, input int c,
                                                          input logic [BYTE_W-1:0] v);
        for (int i = 0; i < PLEN; i++) begin
            if (i == c) begin
                if (v == '0) return v;
            end else if (!byte_loaded[p][i]) begin
                return '0;
            end else if (pattern_bytes[p][i] == '0) begin
                return v;
            end
        end
        return v;
    endfunction

    // A load anywhere, but never into an armed pattern while a wait is in progress; a tick if all are armed.
    task automatic send_random_load();
        int p, c;
        logic [BYTE_W-1:0] v;
        if (awaiting_reply && armed_count >= NPAT) begin
            send_plain(ACT_TICK);
            return;
        end
        p = awaiting_reply ? $urandom_range(NPAT - 1, armed_count) : $urandom_range(NPAT - 1, 0);
        c = $urandom_range(PLEN - 1, 0);
        v = ($urandom_range(3, 0) == 0) ? '0 : alpha_byte();
        send_load(p, c, keep_terminated(p, c, v));
    endtask

    // Loads a whole pattern: mostly short, sometimes long, full length or empty.
    task automatic load_random_string(input int p);
        int len, roll;
        roll = $urandom_range(99, 0);
        if (roll < 3)       len = 0;
        else if (roll < 80) len = $urandom_range(6, 1);
        else if (roll < 92) len = $urandom_range(PLEN - 1, 7);
        else                len = PLEN;
        for (int i = 0; i < len; i++) send_load(p, i, alpha_byte());
        if (len < PLEN) send_load(p, len, '0);
    endtask

    // A typical exchange: load some replies, arm, then feed one of them with noise around it.
    task automatic script_session();
        int n, eff, target, k, steps, roll;
        bit clean;
        logic [BYTE_W-1:0] script [$];
        n     = pick_count();
        eff   = (n > NPAT) ? NPAT : n;
        clean = $urandom_range(1, 0);
        if (eff > 0)
            repeat ($urandom_range(3, 1)) load_random_string($urandom_range(eff - 1, 0));
        send_start(n);
        target = (eff > 0) ? $urandom_range(eff - 1, 0) : 0;
        for (int i = 0; i < PLEN && pattern_bytes[target][i] != '0; i++)
            script.push_back(pattern_bytes[target][i]);
        k = 0;
        steps = 0;
        while (awaiting_reply && steps < 80) begin
            roll = $urandom_range(99, 0);
            if (clean && roll >= 95) roll = 85;
            else if (clean) roll = 0;
            if (roll < 72) begin
                send_recv(script.size() > 0 ? script[k % script.size()] : alpha_byte());
                k++;
            end else if (roll < 82) begin
                send_recv(alpha_byte());
                k = 0;
            end else if (roll < 90) begin
                send_plain(ACT_TICK);
            end else if (roll < 93) begin
                send_random_load();
            end else if (roll < 95) begin
                send_plain(ACTION_W'($urandom_range(UNKNOWN_HI, UNKNOWN_LO)));
            end else if (roll < 96) begin
                send_plain(ACT_RXERR);
            end else if (roll < 97) begin
                send_start(n);
                k = 0;
            end else begin
                send_recv('0);
                k = 0;
            end
            steps++;
        end
    endtask

    // Arms and mostly ticks, so that the wait tends to run out.
    task automatic timeout_session();
        int steps, roll;
        send_start(pick_count());
        steps = 0;
        while (awaiting_reply && steps < 40) begin
            roll = $urandom_range(99, 0);
            if (roll < 85)      send_plain(ACT_TICK);
            else if (roll < 95) send_recv(alpha_byte());
            else                send_plain(ACTION_W'($urandom_range(UNKNOWN_HI, UNKNOWN_LO)));
            steps++;
        end
    endtask

    // Random actions with random fields.
    task automatic noise_session();
        logic [ACTION_W-1:0] act;
        repeat (8) begin
            act = ACTION_W'($urandom_range(UNKNOWN_HI, 0));
            case (act)
                ACT_LOAD:  send_random_load();
                ACT_START: send_start($urandom_range(127, 0));
                ACT_RECV:  send_recv(BYTE_W'($urandom_range(255, 0)));
                default:   send_plain(act);
            endcase
        end
    endtask

    // Words while idle are ignored; an empty wait ends only by tick or error.
    task automatic test_idle_and_empty_wait();
        send_recv(8'hFF);
        send_plain(ACT_TICK);
        send_plain(ACT_RXERR);
        send_plain(ACTION_W'(UNKNOWN_HI));
        send_start(0);
        send_plain(ACTION_W'(UNKNOWN_LO));
        send_plain(ACT_RXERR);
    endtask

    // Every pattern starts out empty; an oversized count saturates and pattern 0 wins at once.
    task automatic test_table_setup();
        for (int p = 0; p < NPAT; p++) send_load(p, 0, '0);
        send_start(127);
    endtask

    // Naive scan, lowest index winning, a load during the wait, a re-arm and an error.
    task automatic test_pattern_priority();
        send_load(0, 0, CH_A);
        send_load(0, 1, CH_A);
        send_load(0, 2, CH_B);
        send_load(0, 3, '0);
        send_load(1, 0, CH_B);
        send_load(1, 1, '0);
        send_load(2, 0, CH_B);
        send_load(2, 1, '0);
        send_start(3);
        repeat (3) send_recv(CH_A);
        send_recv(CH_B);
        send_start(1);
        send_load(0, 2, '0);
        send_recv(CH_A);
        send_recv(CH_A);
        send_start(64);
        send_start(1);
        send_plain(ACT_RXERR);
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_output_stall();
        stall_asks++;
        repeat (16) begin
            if ($urandom_range(1, 0)) send_random_load();
            else send_plain(ACT_TICK);
        end
    endtask

    // Random exchanges under one timeout setting.
    task automatic test_random_scripts(input logic [TIMEOUT_W-1:0] ticks, input int n_words);
        int stop_at, roll;
        write_timeout(ticks);
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            roll = $urandom_range(99, 0);
            if (roll < 70)      script_session();
            else if (roll < 85) timeout_session();
            else                noise_session();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 46;
        test_idle_and_empty_wait();
        test_table_setup();
        test_pattern_priority();
        test_output_stall();
        test_random_scripts(16'd3, 290);
        test_random_scripts(16'd0, 290);

        send_idle_pct = 46;
        recv_idle_pct = 36;
        test_random_scripts(16'hFFFF, 290);
        test_random_scripts(16'd1, 290);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_scripts(16'd9, 290);
        test_random_scripts(16'd40, 290);

        wait_drained();
        repeat (2 * NPAT) @(posedge aclk);
        $display("Run covered %0d input words and %0d result words: %0d matches, %0d timeouts,",
                 words_sent, replies_seen, matches_seen, timeouts_seen);
        $display("%0d receive errors, timeouts from 0 to 65535 and one long output stall.",
                 rxerrs_seen);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/mprm_pkg.sv
rtl/core/mprm_ctl.sv
rtl/core/mprm_dp.sv
rtl/core/multi_pattern_reply_matcher.sv
sim/multi_pattern_reply_matcher_tb.sv
